// ===== sv/aabb_build_and_distance_query_macros.svh =====
// Assertion helpers shared by the block.
`ifndef AABB_BUILD_AND_DISTANCE_QUERY_MACROS_SVH
`define AABB_BUILD_AND_DISTANCE_QUERY_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define AABB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define AABB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/aabb_pkg.sv =====
package aabb_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int NAXES          = 3;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_PRIM  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_SUMMARY = 2'd0,
        KIND_QUERY   = 2'd1,
        KIND_PRIM    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GAP,
        ST_SQ,
        ST_OUT
    } t_state;

    // per-lane pipeline control
    typedef struct packed {
        logic ld_gap;
        logic ld_sq;
        logic prim;
    } t_lane_ctl;

endpackage

// ===== sv/aabb_lane.sv =====
// One axis: outside gap, its square, extent and bound sum.
module aabb_lane import aabb_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  t_lane_ctl                    i_ctl,
    input  logic signed [COORD_BITS-1:0] i_pt,
    input  logic signed [COORD_BITS-1:0] i_qmin,
    input  logic signed [COORD_BITS-1:0] i_qmax,
    input  logic signed [COORD_BITS-1:0] i_bmin,
    input  logic signed [COORD_BITS-1:0] i_bmax,
    output logic [2*COORD_BITS-1:0]      o_sq,
    output logic                         o_out,
    output logic signed [COORD_BITS:0]   o_range,
    output logic signed [COORD_BITS:0]   o_mid
);

    localparam int CB = COORD_BITS;

    logic signed [CB-1:0] w_lo, w_hi;
    logic                 w_above, w_below;
    logic signed [CB:0]   w_d_above, w_d_below;
    logic [CB-1:0]        n_gap;
    logic                 n_out;
    logic [2*CB-1:0]      w_gap_ext;

    logic [CB-1:0]        r_gap;
    logic                 r_out;
    logic signed [CB:0]   r_range, r_mid;
    logic [2*CB-1:0]      r_sq;

    always_comb begin
        w_lo      = i_ctl.prim ? i_qmin : i_pt;
        w_hi      = i_ctl.prim ? i_qmax : i_pt;
        w_above   = w_lo > i_bmax;
        w_below   = w_hi < i_bmin;
        w_d_above = {w_lo[CB-1], w_lo} - {i_bmax[CB-1], i_bmax};
        w_d_below = {i_bmin[CB-1], i_bmin} - {w_hi[CB-1], w_hi};
        n_out     = w_above | w_below;
        // point query tests below first, primitive bound tests above first
        if (i_ctl.prim) begin
            n_gap = w_above ? w_d_above[CB-1:0] :
                    (w_below ? w_d_below[CB-1:0] : '0);
        end else begin
            n_gap = w_below ? w_d_below[CB-1:0] :
                    (w_above ? w_d_above[CB-1:0] : '0);
        end
        w_gap_ext = {{CB{1'b0}}, r_gap};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_gap) begin
            r_gap   <= n_gap;
            r_out   <= n_out;
            r_range <= {i_bmax[CB-1], i_bmax} - {i_bmin[CB-1], i_bmin};
            r_mid   <= {i_bmax[CB-1], i_bmax} + {i_bmin[CB-1], i_bmin};
        end
        if (i_ctl.ld_sq) begin
            r_sq <= w_gap_ext * w_gap_ext;
        end
    end

    assign o_sq    = r_sq;
    assign o_out   = r_out;
    assign o_range = r_range;
    assign o_mid   = r_mid;

endmodule

// ===== sv/aabb_merge.sv =====
// Combines lanes: distance sum, inside flag, longest axis and its midpoint.
module aabb_merge import aabb_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic [2*COORD_BITS-1:0]      i_sq    [NAXES],
    input  logic                         i_out   [NAXES],
    input  logic signed [COORD_BITS:0]   i_range [NAXES],
    input  logic signed [COORD_BITS:0]   i_mid   [NAXES],
    output logic [2*COORD_BITS+1:0]      o_sum,
    output logic                         o_inside,
    output logic [1:0]                   o_axis,
    output logic signed [COORD_BITS-1:0] o_center
);

    localparam int CB = COORD_BITS;

    logic signed [CB:0] w_best, w_mid, w_half;

    always_comb begin
        o_sum = {2'b00, i_sq[0]} + {2'b00, i_sq[1]} + {2'b00, i_sq[2]};
        o_inside = !(i_out[0] | i_out[1] | i_out[2]);

        // first axis wins a tie
        o_axis = 2'd0;
        w_best = i_range[0];
        if (i_range[1] > w_best) begin
            o_axis = 2'd1;
            w_best = i_range[1];
        end
        if (i_range[2] > w_best) begin
            o_axis = 2'd2;
        end

        case (o_axis)
            2'd1:    w_mid = i_mid[1];
            2'd2:    w_mid = i_mid[2];
            default: w_mid = i_mid[0];
        endcase
        w_half   = w_mid >>> 1;     // arithmetic shift gives floor
        o_center = w_half[CB-1:0];
    end

endmodule

// ===== sv/aabb_build_and_distance_query.sv =====
// Channel | Valid       | Stall        | Payload
// --------+-------------+--------------+------------------------------------------
// in      | i_in_valid  | o_in_stall   | i_mode, i_coord_x/y/z, i_last_point
// out     | o_out_valid | i_out_stall  | o_result_kind, o_squared_distance,
//         |             |              | o_inside_res, o_split_axis, o_split_center
//
// A clear, a non-final add or a non-final primitive point updates the boxes at
// the accepting edge; the next transaction can follow at once.
// A transaction that produces a result passes through accept, gap, square and
// merge into the output register. The three-lane gap/square pipeline holds one
// transaction at a time, so o_in_stall is high after the accept through the merge step.
// The merge step waits while the output register holds an untaken result.
// Reset (synchronous, active low) empties both boxes and drops any pending result.
module aabb_build_and_distance_query import aabb_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_mode,
    input  logic signed [COORD_BITS-1:0]   i_coord_x,
    input  logic signed [COORD_BITS-1:0]   i_coord_y,
    input  logic signed [COORD_BITS-1:0]   i_coord_z,
    input  logic                           i_last_point,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_result_kind,
    output logic [2*COORD_BITS+1:0]        o_squared_distance,
    output logic                           o_inside_res,
    output logic [1:0]                     o_split_axis,
    output logic signed [COORD_BITS-1:0]   o_split_center
);

`include "aabb_build_and_distance_query_macros.svh"

    localparam int CB = COORD_BITS;
    localparam int SB = 2 * CB + 2;
    localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

    // ---- state ----
    t_state               r_state, n_state;
    t_mode                r_mode;
    logic signed [CB-1:0] r_pt   [NAXES];
    logic signed [CB-1:0] r_bmin [NAXES];
    logic signed [CB-1:0] r_bmax [NAXES];
    logic signed [CB-1:0] r_qmin [NAXES];
    logic signed [CB-1:0] r_qmax [NAXES];

    // output register
    logic                 r_out_valid;
    t_kind                r_kind;
    logic [SB-1:0]        r_dist;
    logic                 r_inside;
    logic [1:0]           r_axis;
    logic signed [CB-1:0] r_center;

    // ---- handshake ----
    logic                 w_in_acc, w_needs_res, w_load_out;
    t_mode                w_mode;
    logic signed [CB-1:0] w_pt [NAXES];
    t_lane_ctl            w_ctl;

    assign w_mode   = t_mode'(i_mode);
    assign w_pt[0]  = i_coord_x;
    assign w_pt[1]  = i_coord_y;
    assign w_pt[2]  = i_coord_z;
    assign w_in_acc = i_in_valid && !o_in_stall;

    // Only final add/primitive points and point queries enter the lane pipeline.
    assign w_needs_res = (w_mode == MODE_QUERY) ||
                         (i_last_point && (w_mode == MODE_ADD || w_mode == MODE_PRIM));

    // ---- FSM next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_acc && w_needs_res) n_state = ST_GAP;
            ST_GAP:  n_state = ST_SQ;
            ST_SQ:   n_state = ST_OUT;
            ST_OUT:  if (w_load_out) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- FSM outputs ----
    always_comb begin
        o_in_stall   = (r_state != ST_IDLE);
        w_ctl.ld_gap = (r_state == ST_GAP);
        w_ctl.ld_sq  = (r_state == ST_SQ);
        w_ctl.prim   = (r_mode == MODE_PRIM);
        // output register is free, or its result leaves this cycle
        w_load_out   = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);
    end

    // ---- box state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MODE_CLEAR;
            for (int a = 0; a < NAXES; a++) begin
                r_bmin[a] <= CMAX;
                r_bmax[a] <= CMIN;
                r_qmin[a] <= CMAX;
                r_qmax[a] <= CMIN;
            end
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_mode <= w_mode;
                for (int a = 0; a < NAXES; a++) begin
                    r_pt[a] <= w_pt[a];
                    case (w_mode)
                        MODE_CLEAR: begin
                            r_bmin[a] <= CMAX;
                            r_bmax[a] <= CMIN;
                        end
                        MODE_ADD: begin
                            if (w_pt[a] < r_bmin[a]) r_bmin[a] <= w_pt[a];
                            if (w_pt[a] > r_bmax[a]) r_bmax[a] <= w_pt[a];
                        end
                        MODE_PRIM: begin
                            if (w_pt[a] < r_qmin[a]) r_qmin[a] <= w_pt[a];
                            if (w_pt[a] > r_qmax[a]) r_qmax[a] <= w_pt[a];
                        end
                        default: ;
                    endcase
                end
            end
            // query box was read by the lanes this cycle; empty it
            if (r_state == ST_GAP && r_mode == MODE_PRIM) begin
                for (int a = 0; a < NAXES; a++) begin
                    r_qmin[a] <= CMAX;
                    r_qmax[a] <= CMIN;
                end
            end
        end
    end

    // ---- lanes ----
    logic [2*CB-1:0]    w_sq    [NAXES];
    logic               w_out   [NAXES];
    logic signed [CB:0] w_range [NAXES];
    logic signed [CB:0] w_mid   [NAXES];

    for (genvar g = 0; g < NAXES; g++) begin : g_lane
        aabb_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pt    (r_pt[g]),
            .i_qmin  (r_qmin[g]),
            .i_qmax  (r_qmax[g]),
            .i_bmin  (r_bmin[g]),
            .i_bmax  (r_bmax[g]),
            .o_sq    (w_sq[g]),
            .o_out   (w_out[g]),
            .o_range (w_range[g]),
            .o_mid   (w_mid[g])
        );
    end

    // ---- merge ----
    logic [SB-1:0]        w_sum;
    logic                 w_inside;
    logic [1:0]           w_axis;
    logic signed [CB-1:0] w_center;

    aabb_merge #(
        .COORD_BITS (COORD_BITS)
    ) u_merge (
        .i_sq     (w_sq),
        .i_out    (w_out),
        .i_range  (w_range),
        .i_mid    (w_mid),
        .o_sum    (w_sum),
        .o_inside (w_inside),
        .o_axis   (w_axis),
        .o_center (w_center)
    );

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // unused fields of each result kind read as zero
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            case (r_mode)
                MODE_ADD: begin
                    r_kind   <= KIND_SUMMARY;
                    r_dist   <= '0;
                    r_inside <= 1'b0;
                    r_axis   <= w_axis;
                    r_center <= w_center;
                end
                MODE_QUERY: begin
                    r_kind   <= KIND_QUERY;
                    r_dist   <= w_sum;
                    r_inside <= w_inside;
                    r_axis   <= 2'd0;
                    r_center <= '0;
                end
                default: begin
                    r_kind   <= KIND_PRIM;
                    r_dist   <= w_sum;
                    r_inside <= 1'b0;
                    r_axis   <= 2'd0;
                    r_center <= '0;
                end
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_result_kind      = r_kind;
    assign o_squared_distance = r_dist;
    assign o_inside_res       = r_inside;
    assign o_split_axis       = r_axis;
    assign o_split_center     = r_center;

    // ---- assertions ----
    `AABB_ASSERT_NXT(a_gap_to_sq, i_clk, i_rst_n, r_state == ST_GAP, r_state == ST_SQ, "gap stage did not advance")
    `AABB_ASSERT_IMP(a_qbox_emptied, i_clk, i_rst_n, r_state == ST_SQ && r_mode == MODE_PRIM, r_qmin[0] == CMAX && r_qmax[0] == CMIN, "query box not emptied after primitive bound")
    `AABB_ASSERT_IMP(a_summary_nodist, i_clk, i_rst_n, o_out_valid && o_result_kind == KIND_SUMMARY, o_squared_distance == '0, "box summary carries a distance")
    `AABB_ASSERT_IMP(a_inside_zero, i_clk, i_rst_n, o_out_valid && o_result_kind == KIND_QUERY && o_inside_res, o_squared_distance == '0, "inside point with nonzero distance")

endmodule
